>>> sv/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  // Request opcodes
  typedef enum logic [2:0] {
    OP_INSERT    = 3'd0,
    OP_PEEK_HEAD = 3'd1,
    OP_POP_HEAD  = 3'd2,
    OP_PEEK_TAIL = 3'd3,
    OP_CLEAR     = 3'd4
  } spq_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } spq_status_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } spq_ctl_t;

endpackage

>>> sv/spq_cell.sv
// One storage cell of the sorted chain: keep, take the new value, or shift.
module spq_cell import spq_pkg::*; (
  input  logic               clk,
  input  spq_ctl_t           ctl,
  input  logic               occ,
  input  logic signed [31:0] ins_val,
  input  logic               left_keep,
  input  logic signed [31:0] left_val,
  input  logic signed [31:0] right_val,
  output logic signed [31:0] val,
  output logic               keep
);

  logic signed [31:0] val_r;
  logic signed [31:0] val_nxt;

  // Hold the slot when it is occupied and not smaller than the new value
  assign keep = occ && (val_r >= ins_val);

  // Pick the next value: shift toward head on pop, make room on insert
  always_comb begin
    val_nxt = val_r;
    if (ctl.pop) begin
      val_nxt = right_val;
    end else if (ctl.ins) begin
      if (keep) begin
        val_nxt = val_r;
      end else if (left_keep) begin
        val_nxt = ins_val;
      end else begin
        val_nxt = left_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;

endmodule

>>> sv/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell chain, control and result register.
// The queue holds up to DEPTH signed 32-bit entries in descending order in a row of
// cells; an insert lands behind every equal or larger entry, so equal values leave in
// arrival order. Every request (insert, peek head, pop head, peek tail, clear) yields
// exactly one result: all cells compare against the new value and shift in
// parallel in the cycle the request is accepted, and the result sits in an output
// register, so a new request is taken every cycle while the result side keeps up.
// The tail is tracked in a separate register. There is no clearing pass after
// reset. Inserts into a full queue are dropped with status full; reads of an
// empty queue return zero with status empty.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status,
  output logic [4:0]         out_entry_count
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0]      count_r;
  logic [CW-1:0]      count_nxt;
  logic signed [31:0] tail_r;
  logic signed [31:0] tail_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic signed [31:0] res_r;
  logic signed [31:0] res_nxt;
  spq_status_t        status_r;
  spq_status_t        status_nxt;
  logic [4:0]         ecount_r;
  logic [4:0]         ecount_nxt;

  logic               accept;
  logic               empty;
  logic               full;
  spq_ctl_t           ctl;
  logic [CW+4:0]      count_ext;

  logic signed [31:0] cell_val  [DEPTH];
  logic               cell_keep [DEPTH];
  logic               cell_occ  [DEPTH];

  assign accept   = in_valid && in_ready;
  assign in_ready = rst_n && (!out_valid_r || out_ready);
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));

  // Build the chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_occ[i] = (CW'(i) < count_r);

    if (i == 0 && DEPTH == 1) begin : g_only
      spq_cell u_cell (
        .clk(clk), .ctl(ctl), .occ(cell_occ[i]), .ins_val(in_value),
        .left_keep(1'b1), .left_val(in_value), .right_val(cell_val[i]),
        .val(cell_val[i]), .keep(cell_keep[i])
      );
    end else if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk(clk), .ctl(ctl), .occ(cell_occ[i]), .ins_val(in_value),
        .left_keep(1'b1), .left_val(in_value), .right_val(cell_val[i+1]),
        .val(cell_val[i]), .keep(cell_keep[i])
      );
    end else if (i == DEPTH - 1) begin : g_last
      spq_cell u_cell (
        .clk(clk), .ctl(ctl), .occ(cell_occ[i]), .ins_val(in_value),
        .left_keep(cell_keep[i-1]), .left_val(cell_val[i-1]), .right_val(cell_val[i]),
        .val(cell_val[i]), .keep(cell_keep[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk(clk), .ctl(ctl), .occ(cell_occ[i]), .ins_val(in_value),
        .left_keep(cell_keep[i-1]), .left_val(cell_val[i-1]), .right_val(cell_val[i+1]),
        .val(cell_val[i]), .keep(cell_keep[i])
      );
    end
  end

  // Decode the request into cell commands, next count, tail and result
  always_comb begin
    ctl        = '0;
    count_nxt  = count_r;
    tail_nxt   = tail_r;
    res_nxt    = '0;
    status_nxt = ST_OK;
    case (spq_op_t'(in_opcode))
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ctl.ins   = accept;
          count_nxt = count_r + CW'(1);
          if (empty || (in_value <= tail_r)) begin
            tail_nxt = in_value;
          end
        end
      end
      OP_PEEK_HEAD: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          res_nxt = cell_val[0];
        end
      end
      OP_POP_HEAD: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          res_nxt   = cell_val[0];
          ctl.pop   = accept;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_PEEK_TAIL: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          res_nxt = tail_r;
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign count_ext  = {5'd0, count_nxt};
  assign ecount_nxt = count_ext[4:0];

  // Hold the result until taken, load on each accepted request
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      tail_r   <= tail_nxt;
      res_r    <= res_nxt;
      status_r <= status_nxt;
      ecount_r <= ecount_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = res_r;
  assign out_status       = status_r;
  assign out_entry_count  = ecount_r;

  // Count never exceeds the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  // A pop of a non-empty queue removes exactly one entry
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_opcode == OP_POP_HEAD && !empty) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("pop did not remove one entry");

  // Head is never smaller than the tracked tail
  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (cell_val[0] >= tail_r))
    else $error("head smaller than tail");

endmodule
